// ===== rtl/mwlfo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared types and constants for the multi-waveform LFO.
// ----------------------------------------------------------------------------
package mwlfo_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int PHASE_BITS_DEF       = 32;

    localparam int DT_W      = 16;
    localparam int FREQ_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int MODE_W    = 3;
    localparam int LFSR_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [LFSR_W-1:0]    LFSR_MASK   = 32'h8020_0003;
    localparam logic [LFSR_W-1:0]    LFSR_SEED   = 32'h0000_0001;
    localparam logic [FREQ_W-1:0]    FREQ_RESET  = 16'd256;
    localparam logic [SAMPLE_W-1:0]  Q15_MAX     = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0]  Q15_MIN     = 16'h8000;
    localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 8'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SQUARE      = 3'd0,
        MODE_SINE        = 3'd1,
        MODE_SAW         = 3'd2,
        MODE_NOISE       = 3'd3,
        MODE_RAND_SQUARE = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [FREQ_W-1:0] frequency;
    } cfg_t;

    // Galois LFSR step, shift right; a stuck zero state restarts from the seed
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = (v == '0) ? LFSR_SEED : v;
        return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mwlfo_sine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwlfo_sine
// Quarter-wave sine lookup: quadrant from the top two phase bits, mirrored
// index in odd quadrants, negated value in the second half period.
// ----------------------------------------------------------------------------
module mwlfo_sine
    import mwlfo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
)
(
    input  wire logic [PHASE_BITS-1:0] phase,
    output logic signed [SAMPLE_W-1:0] sine
);

    localparam int AddrW = $clog2(SINE_TABLE_DEPTH);
    localparam int IdxW  = AddrW + 2;

    // Q30 Taylor series, evaluated at elaboration only
    function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0]    x;
        logic [63:0]    x2;
        logic [63:0]    t;
        longint         sum;
        longint         v;
        x   = (HALF_PI_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        t   = ((t * x2) >> 30) / 6;   sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 20;  sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 42;  sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 72;  sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 110; sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 156; sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 210; sum = sum - longint'(t);
        if (sum < 0)
            sum = 0;
        v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
        if (v > 32767)
            v = 32767;
        return SAMPLE_W'(v);
    endfunction

    logic [SAMPLE_W-1:0] tab [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_tab
        localparam logic [SAMPLE_W-1:0] Entry = sine_entry(g);
        assign tab[g] = Entry;
    end

    logic [IdxW-1:0]  idx;
    logic [1:0]       quad;
    logic [AddrW-1:0] k;
    logic [AddrW:0]   addr;
    logic [SAMPLE_W-1:0] mag;

    always_comb
    begin
        idx  = phase[PHASE_BITS-1 -: IdxW];
        quad = idx[IdxW-1 -: 2];
        k    = idx[AddrW-1:0];
        addr = quad[0] ? ((AddrW+1)'(SINE_TABLE_DEPTH) - {1'b0, k}) : {1'b0, k};
        mag  = tab[addr];
        sine = quad[1] ? -$signed(mag) : $signed(mag);
    end

endmodule
`default_nettype wire

// ===== rtl/mwlfo_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwlfo_core
// Oscillator state: phase accumulator, noise LFSR and random-square hold.
// Forms the sample from the current state and advances it on each fire.
// ----------------------------------------------------------------------------
module mwlfo_core
    import mwlfo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic [DT_W-1:0]      delta_t,
    input  wire cfg_t                 cfg,
    output logic [SAMPLE_W-1:0]       sample
);

    localparam int IncUp   = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
    localparam int IncDown = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int ProdW   = DT_W + FREQ_W;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [LFSR_W-1:0]     lfsr_reg, lfsr_next;
    logic [SAMPLE_W-1:0]   held_reg, held_next;
    logic                  was_second_reg, was_second_next;

    logic signed [SAMPLE_W-1:0] sine;
    logic [LFSR_W-1:0]          lfsr_stepped;
    logic                       second;
    logic [SAMPLE_W-1:0]        top16;
    logic [ProdW-1:0]           prod;
    logic [PHASE_BITS+ProdW-1:0] prod_wide;
    logic [PHASE_BITS-1:0]      inc;

    mwlfo_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_sine (
        .phase (phase_reg),
        .sine  (sine)
    );

    always_comb
    begin
        second       = phase_reg[PHASE_BITS-1];
        top16        = phase_reg[PHASE_BITS-1 -: SAMPLE_W];
        lfsr_stepped = lfsr_step(lfsr_reg);
        lfsr_next       = lfsr_reg;
        held_next       = held_reg;
        was_second_next = was_second_reg;
        case (cfg.mode)
            MODE_SQUARE:
                sample = second ? Q15_MAX : Q15_MIN;
            MODE_SINE:
                sample = sine;
            MODE_SAW:
                sample = top16 ^ Q15_MIN;
            MODE_NOISE:
            begin
                lfsr_next = lfsr_stepped;
                sample    = lfsr_stepped[SAMPLE_W-1:0];
            end
            MODE_RAND_SQUARE:
            begin
                if (!second && was_second_reg)
                begin
                    lfsr_next = lfsr_stepped;
                    held_next = lfsr_stepped[SAMPLE_W-1:0];
                end
                else if (second && !was_second_reg)
                begin
                    held_next = (held_reg == Q15_MIN) ? Q15_MAX : -held_reg;
                end
                was_second_next = second;
                sample          = held_next;
            end
            default:
                sample = '0;
        endcase

        prod       = delta_t * cfg.frequency;
        prod_wide  = {{PHASE_BITS{1'b0}}, prod};
        inc        = PHASE_BITS'((prod_wide << IncUp) >> IncDown);
        phase_next = phase_reg + inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            lfsr_reg       <= LFSR_SEED;
            held_reg       <= '0;
            was_second_reg <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            lfsr_reg       <= lfsr_next;
            held_reg       <= held_next;
            was_second_reg <= was_second_next;
        end
    end

    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cfg.mode == MODE_NOISE || cfg.mode == MODE_RAND_SQUARE)
        |=> lfsr_reg != '0)
        else $error("LFSR stuck at zero after a step");

    a_half_track: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cfg.mode != MODE_RAND_SQUARE |=> $stable(was_second_reg))
        else $error("half-period flag moved outside random square");

    a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cfg.frequency == '0 |=> $stable(phase_reg))
        else $error("phase advanced at zero frequency");

endmodule
`default_nettype wire

// ===== rtl/multi_waveform_lfo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_lfo
// Phase-accumulator LFO: square, sine, saw, noise and random square outputs.
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    s_tdata[15:0] delta_t
//   m_*      out  m_tvalid / m_tready    m_tdata[15:0] sample (Q1.15)
//   cfg_*    in   cfg_valid / cfg_ready  cfg_index (0 mode, 1 frequency), cfg_data
//
// One request per cycle sustained while m_tready stays high; a request passes the
// input register, then the multiply-add and waveform logic into the output
// register. The phase multiply-add is the longest path.
// rst_n clears the state to phase 0, LFSR 1, mode square, frequency 256.
// m_tready low holds the output register; s_tready then stays high only while
// the input register is empty. cfg_ready is always high.
// ----------------------------------------------------------------------------
module multi_waveform_lfo
    import mwlfo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DT_W-1:0]       s_tdata,     // [15:0] delta_t
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [SAMPLE_W-1:0]        m_tdata,     // [15:0] sample
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

    logic                in_valid_reg;
    logic [DT_W-1:0]     dt_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    cfg_t                cfg_reg;
    logic                fire;
    logic [SAMPLE_W-1:0] sample;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = sample_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            cfg_reg.mode      <= MODE_SQUARE;
            cfg_reg.frequency <= FREQ_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_index == CFG_MODE)
                cfg_reg.mode <= mode_t'(cfg_data[MODE_W-1:0]);
            if (cfg_valid && cfg_index == CFG_FREQUENCY)
                cfg_reg.frequency <= cfg_data[FREQ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            dt_reg <= s_tdata;
        if (fire)
            sample_reg <= sample;
    end

    mwlfo_core #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .delta_t (dt_reg),
        .cfg     (cfg_reg),
        .sample  (sample)
    );

    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed request did not reach the output");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("empty input register refused a request");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(dt_reg))
        else $error("pending request lost while stalled");

endmodule
`default_nettype wire

// ===== bench/tb_multi_waveform_lfo.sv =====
// ----------------------------------------------------------------------------
// tb_multi_waveform_lfo
// Self-checking bench for the phase-accumulator LFO. A cycle-free model of the
// oscillator predicts one sample per delta_t request. Directed checks cover the
// reset settings, every waveform including the unused modes, and a stopped
// phase. Random ticks then run under changing mode and frequency, with bursty
// input traffic and several output stall patterns.
// ----------------------------------------------------------------------------
module tb_multi_waveform_lfo;
    timeunit 1ns;
    timeprecision 1ps;
    import mwlfo_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_TICKS   = 600;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LUT_DEPTH      = SINE_TABLE_DEPTH_DEF;
    localparam int LUT_AW         = $clog2(LUT_DEPTH);
    localparam int PHASE_W        = PHASE_BITS_DEF;
    localparam int MODE_LAST      = (1 << MODE_W) - 1;
    localparam int CFG_INDEX_LAST = (1 << CFG_IDX_W) - 1;
    localparam logic [DT_W-1:0]   DT_MAX   = '1;
    localparam logic [DT_W-1:0]   DT_HALF  = DT_W'(1 << (DT_W - 1));
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_style_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DT_W-1:0]      s_tdata = '0;       // [15:0] delta_t
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;            // [15:0] sample
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // oscillator model state
    logic [PHASE_W-1:0]   phase_acc;
    logic [LFSR_W-1:0]    noise_state;
    logic [SAMPLE_W-1:0]  held_level;
    bit                   held_was_high;
    logic [MODE_W-1:0]    lfo_mode;
    logic [FREQ_W-1:0]    lfo_freq;
    int                   sine_lut [0:LUT_DEPTH];
    logic [SAMPLE_W-1:0]  sample_q [$];

    logic [SAMPLE_W-1:0]  sample_exp;
    int                   fail_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 0;
    rx_style_t            rx_style = RX_ALWAYS;
    int                   rx_run = 0;
    bit                   rx_level = 1'b1;
    int unsigned          rx_phase = 0;

    multi_waveform_lfo uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // quarter-wave sine entry, Q30 Taylor series rounded to Q1.15
    function automatic int sine_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        x = (HALF_PI_Q30 * longint'(i) + LUT_DEPTH / 2) / LUT_DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 32767 + (longint'(1) << 29)) >>> 30;
        if (v > 32767)
            v = 32767;
        return int'(v);
    endfunction

    function automatic logic [LFSR_W-1:0] noise_advance(input logic [LFSR_W-1:0] v);
        if (v == '0)
            v = LFSR_SEED;
        return v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    endfunction

    function automatic logic [DT_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DT_MAX;
            2, 3:    return DT_W'($urandom_range(1, 255));
            default: return DT_W'($urandom);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FREQ_MAX;
            2, 3:    return FREQ_W'($urandom_range(1, 64));
            4, 5:    return FREQ_W'($urandom_range(256, 4096));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    // sample is formed from the phase before the advance
    task automatic predict_tick(input logic [DT_W-1:0] dt);
        logic [SAMPLE_W-1:0] s;
        logic [LUT_AW+1:0]   idx;
        logic [LUT_AW-1:0]   k;
        logic [SAMPLE_W-1:0] mag;
        bit                  upper;
        upper = phase_acc[PHASE_W-1];
        s = '0;
        case (lfo_mode)
            MODE_SQUARE:
                s = upper ? Q15_MAX : Q15_MIN;
            MODE_SINE:
            begin
                idx = phase_acc[PHASE_W-1 -: LUT_AW+2];
                k = idx[LUT_AW-1:0];
                // odd quadrants run the table backwards, the second half negates
                if (idx[LUT_AW])
                    mag = SAMPLE_W'(sine_lut[LUT_DEPTH - int'(k)]);
                else
                    mag = SAMPLE_W'(sine_lut[k]);
                s = idx[LUT_AW+1] ? -mag : mag;
            end
            MODE_SAW:
                s = phase_acc[PHASE_W-1 -: SAMPLE_W] - Q15_MIN;
            MODE_NOISE:
            begin
                noise_state = noise_advance(noise_state);
                s = noise_state[SAMPLE_W-1:0];
            end
            MODE_RAND_SQUARE:
            begin
                if (!upper)
                begin
                    if (held_was_high)
                    begin
                        noise_state = noise_advance(noise_state);
                        held_level = noise_state[SAMPLE_W-1:0];
                    end
                end
                else if (!held_was_high)
                begin
                    held_level = (held_level == Q15_MIN) ? Q15_MAX : -held_level;
                end
                held_was_high = upper;
                s = held_level;
            end
            default:
                s = '0;
        endcase
        phase_acc = phase_acc + PHASE_W'(dt) * PHASE_W'(lfo_freq);
        sample_q.push_back(s);
    endtask

    // output stall patterns
    always @(negedge clk)
    begin
        rx_phase++;
        case (rx_style)
            RX_ALWAYS:
                m_tready <= 1'b1;
            RX_RANDOM:
                m_tready <= ($urandom_range(0, 99) < 65);
            RX_PERIODIC:
                m_tready <= ((rx_phase % 7) < 4);
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_level = ~rx_level;
                    rx_run = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 20);
                end
                rx_run--;
                m_tready <= rx_level;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sample_q.size() == 0)
            begin
                $error("sample: no request pending, actual %0d", $signed(m_tdata));
                fail_count++;
            end
            else
            begin
                sample_exp = sample_q.pop_front();
                if (m_tdata !== sample_exp)
                begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           $signed(sample_exp), $signed(m_tdata));
                    fail_count++;
                end
            end
        end
    end

    // one delta_t request; returns at the accepting edge
    task automatic send_tick(input logic [DT_W-1:0] dt);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= dt;
        do @(posedge clk); while (!s_tready);
        predict_tick(dt);
    endtask

    // stop sending and wait until every pending sample is back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sample_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_MODE)
            lfo_mode = data[MODE_W-1:0];
        else if (idx == CFG_FREQUENCY)
            lfo_freq = data[FREQ_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits are don't-care for the mode register
    task automatic set_mode(input int m);
        logic [CFG_DAT_W-1:0] data;
        data = CFG_DAT_W'($urandom);
        data[MODE_W-1:0] = MODE_W'(m);
        write_reg(CFG_MODE, data);
    endtask

    task automatic test_reset_defaults();
        send_tick('0);
        send_tick(DT_MAX);
        send_tick(DT_W'(1));
        drain_results();
    endtask

    // fast sweep so each mode sees several phase regions, unused modes included
    task automatic test_every_waveform();
        write_reg(CFG_FREQUENCY, FREQ_MAX);
        for (int m = 0; m <= MODE_LAST; m++)
        begin
            set_mode(m);
            send_tick(DT_MAX);
            send_tick(DT_HALF);
            drain_results();
        end
    endtask

    task automatic test_stopped_phase();
        rx_style = RX_PERIODIC;
        write_reg(CFG_FREQUENCY, '0);
        write_reg(CFG_INDEX_LAST, '1);
        set_mode(MODE_SAW);
        send_tick(DT_MAX);
        send_tick(DT_MAX);
        drain_results();
    endtask

    task automatic test_random_ticks();
        int sent;
        int ph;
        int len;
        int m;
        sent = 0;
        ph = 0;
        while (sent < RANDOM_TICKS)
        begin
            if (ph == 0)
                write_reg(CFG_FREQUENCY, FREQ_MAX);
            else if (ph == 1)
                write_reg(CFG_FREQUENCY, FREQ_W'(1));
            else
                write_reg(CFG_FREQUENCY, pick_freq());
            m = $urandom_range(0, MODE_LAST + 4);
            if (m > MODE_LAST)
                m = $urandom_range(MODE_SQUARE, MODE_RAND_SQUARE);
            set_mode(m);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_FREQUENCY + 1, CFG_INDEX_LAST)),
                          CFG_DAT_W'($urandom));
            rx_style = rx_style_t'($urandom_range(RX_ALWAYS, RX_BURSTY));
            len = $urandom_range(20, 80);
            for (int i = 0; i < len; i++)
            begin
                send_tick(pick_delta());
                if (i == len / 2 && (ph == 0 || $urandom_range(0, 3) == 0))
                    drain_results();
            end
            sent += len;
            ph++;
            drain_results();
        end
    endtask

    initial
    begin
        for (int i = 0; i <= LUT_DEPTH; i++)
            sine_lut[i] = sine_entry(i);
        phase_acc = '0;
        noise_state = LFSR_SEED;
        held_level = '0;
        held_was_high = 1'b1;
        lfo_mode = MODE_SQUARE;
        lfo_freq = FREQ_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_every_waveform();
        test_stopped_phase();
        test_random_ticks();
        drain_results();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== multi_waveform_lfo.f =====
rtl/mwlfo_pkg.sv
rtl/mwlfo_sine.sv
rtl/mwlfo_core.sv
rtl/multi_waveform_lfo.sv
bench/tb_multi_waveform_lfo.sv
